@@ rtl/class_priority_job_queue_top_defines.svh @@
// Assertion macros shared by the job queue RTL.
// No dependencies; included by the files that carry assertions.
`ifndef CLASS_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH
`define CLASS_PRIORITY_JOB_QUEUE_TOP_DEFINES_SVH

// Clocked property, ignored while reset is asserted
`define CPJQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset
`define CPJQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/cpjq_pkg.sv @@
// Types and codes for the class-ordered job queue.
// No dependencies; used by cpjq_cell and class_priority_job_queue_top.
`default_nettype none

package cpjq_pkg;

    // Operation codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // One queued job
    typedef struct packed {
        logic [1:0] job_class;
        logic [7:0] job_pages;
    } job_t;

    // Request transaction
    typedef struct packed {
        logic       op;
        logic [1:0] job_class;
        logic [7:0] job_pages;
    } req_t;

    // Result transaction
    typedef struct packed {
        logic       out_valid;
        logic [1:0] out_class;
        logic [7:0] out_pages;
        logic [1:0] status;
    } resp_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic push;
        logic pop;
        job_t job;
    } cell_ctrl_t;

    // What a cell shows its neighbours
    typedef struct packed {
        logic valid;
        logic keep;
        job_t job;
    } cell_link_t;

endpackage

`default_nettype wire

@@ rtl/cpjq_cell.sv @@
// One slot of the sorted job chain: holds a job and its occupancy bit.
// Depends on cpjq_pkg.
`default_nettype none

module cpjq_cell (
    input  wire                  clk,
    input  wire                  rst_n,
    input  cpjq_pkg::cell_ctrl_t ctrl,
    input  cpjq_pkg::cell_link_t prev_link,
    input  cpjq_pkg::cell_link_t next_link,
    output cpjq_pkg::cell_link_t link
);
    import cpjq_pkg::*;

    logic valid_reg;
    logic valid_next;
    job_t job_reg;
    job_t job_next;
    logic keep;

    // Job stays put on insert when it sorts at or ahead of the new class
    assign keep = valid_reg && (job_reg.job_class <= ctrl.job.job_class);

    assign link.valid = valid_reg;
    assign link.keep  = keep;
    assign link.job   = job_reg;

    // Insert shifts the tail back one place; pop pulls everything forward
    always_comb
    begin
        valid_next = valid_reg;
        job_next   = job_reg;
        if (ctrl.push)
        begin
            if (!keep)
            begin
                valid_next = valid_reg | prev_link.valid;
                job_next   = prev_link.keep ? ctrl.job : prev_link.job;
            end
        end
        else if (ctrl.pop)
        begin
            valid_next = next_link.valid;
            job_next   = next_link.job;
        end
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Job payload
    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

`default_nettype wire

@@ rtl/class_priority_job_queue_top.sv @@
// Class-ordered job queue: a chain of cpjq_cell slots kept sorted by class.
// Depends on cpjq_pkg, cpjq_cell and class_priority_job_queue_top_defines.svh.
`default_nettype none

// One transaction is taken on every cycle: busy never rises, so start may be
// held high. Each transaction gives exactly one result, shown on resp for the
// single cycle that done is high, in the cycle after the start cycle; the
// receiver has no way to stall it and must capture it then. Enqueue inserts
// the job behind all queued jobs of the same or a lower class in that cycle,
// by a class compare broadcast to all QUEUE_DEPTH cells, and that fan-out
// sets the clock rate. A full queue rejects an enqueue with status full; a
// dequeue on an empty queue reports status empty.
module class_priority_job_queue_top #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              start,
    output logic             busy,
    input  cpjq_pkg::req_t   req,
    output logic             done,
    output cpjq_pkg::resp_t  resp
);
    import cpjq_pkg::*;
    `include "class_priority_job_queue_top_defines.svh"

    cell_ctrl_t               ctrl;
    cell_link_t               links [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   occ_vec;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     done_reg;
    resp_t                    resp_reg;
    resp_t                    resp_next;

    // Chain ends: a virtual full head before slot 0, an empty slot after the tail
    localparam cell_link_t HEAD_BOUND = '{valid: 1'b1, keep: 1'b1, job: '0};
    localparam cell_link_t TAIL_BOUND = '{valid: 1'b0, keep: 1'b0, job: '0};

    assign busy   = 1'b0;
    assign accept = start;
    assign full   = links[QUEUE_DEPTH-1].valid;
    assign empty  = !links[0].valid;

    // Command broadcast
    assign ctrl.push = accept && (req.op == OP_ENQ) && !full;
    assign ctrl.pop  = accept && (req.op == OP_DEQ) && !empty;
    assign ctrl.job  = '{job_class: req.job_class, job_pages: req.job_pages};

    // Slot chain
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        cell_link_t prev_l;
        cell_link_t next_l;
        if (i == 0)
        begin : g_first
            assign prev_l = HEAD_BOUND;
        end
        else
        begin : g_mid_prev
            assign prev_l = links[i-1];
        end
        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_l = TAIL_BOUND;
        end
        else
        begin : g_mid_next
            assign next_l = links[i+1];
        end
        cpjq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .prev_link (prev_l),
            .next_link (next_l),
            .link      (links[i])
        );
        assign occ_vec[i] = links[i].valid;
    end

    // Result for this transaction
    always_comb
    begin
        resp_next = '0;
        if (req.op == OP_ENQ)
        begin
            resp_next.status = full ? ST_FULL : ST_OK;
        end
        else if (empty)
        begin
            resp_next.status = ST_EMPTY;
        end
        else
        begin
            resp_next.out_valid = 1'b1;
            resp_next.out_class = links[0].job.job_class;
            resp_next.out_pages = links[0].job.job_pages;
            resp_next.status    = ST_OK;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        resp_reg <= resp_next;
    end

    assign done = done_reg;
    assign resp = resp_reg;

    // Checks
    `CPJQ_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
    `CPJQ_ASSERT(a_occ_thermo, ((occ_vec & (occ_vec + QUEUE_DEPTH'(1))) == '0), "occupancy has a hole")
    `CPJQ_ASSERT(a_push_grows, ctrl.push |=> ($countones(occ_vec) == $past($countones(occ_vec)) + 1), "insert did not add one job")
    `CPJQ_ASSERT(a_pop_returns, ctrl.pop |=> (done && resp.out_valid && resp.status == ST_OK), "dequeue returned no job")
    `CPJQ_ASSERT(a_valid_ok, (done && resp.out_valid) |-> (resp.status == ST_OK), "job returned with error status")

endmodule

`default_nettype wire
